[sv/sawfp_pkg.sv]
// segment allocator pkg: table sizes, field widths, cmd/status/fit/reg codes
// no dependencies
package sawfp_pkg;
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned MaxHoles    = 64;
  localparam int unsigned MemBytes    = 4096;
  localparam int unsigned SegIdxW     = $clog2(MaxSegments);
  localparam int unsigned HoleIdxW    = $clog2(MaxHoles);
  localparam int unsigned SegCntW     = $clog2(MaxSegments + 1);
  localparam int unsigned HoleCntW    = $clog2(MaxHoles + 1);
  localparam int unsigned SzW         = 13;
  localparam int unsigned AddrW       = 12;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_ACCESS  = 3'd2,
    CMD_FREE    = 3'd3,
    CMD_COMPACT = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FAULT    = 2'd1,
    ST_COMPACT  = 2'd2,
    ST_OOM      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FIT_BEST  = 2'd0,
    FIT_WORST = 2'd1,
    FIT_FIRST = 2'd2,
    FIT_ALT   = 2'd3
  } fit_e;

  typedef enum logic [1:0] {
    REG_MEM_SIZE = 2'd0,
    REG_RES_SIZE = 2'd1,
    REG_FIT      = 2'd2,
    REG_NONE     = 2'd3
  } reg_e;

  typedef struct packed {
    logic [7:0]     pid;
    logic [3:0]     seg_id;
    logic [SzW-1:0] base;
    logic [SzW-1:0] size;
  } seg_t;

  typedef struct packed {
    logic [SzW-1:0] base;
    logic [SzW-1:0] size;
  } hole_t;
endpackage

[sv/segment_allocator_with_fit_policies.sv]
// segment allocator with best, worst and first fit placement
// depends on sawfp_pkg; checker lives in sawfp_checker.sv
//
// channel   direction  handshake          payload
// cfg       in         cfg_valid/ready    cfg_index_i, cfg_data_i
// in        in         in_valid/stall     cmd, pid, seg_id, size, offset, length
// out       out        out_valid/stall    status, address
//
// one command at a time; a small sequencer walks the tables one table entry per cycle
// access is one segment pass; create and delete are a segment pass plus a hole pass,
// and delete compacts if the hole table is full; compact is one segment pass per placed
// segment plus a final pass; free process: one segment pass plus a hole pass per deleted segment
// reset and any write to mem_size or reserved_size rebuild the tables in S_CLEAR
// (valid bits cleared at once), no commands accepted meanwhile
// a finished result sits in its own output register, held while out_stall is high;
// the next command may start while it waits, config waits until it is taken
module segment_allocator_with_fit_policies
  import sawfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index_i,
  input  logic [12:0]      cfg_data_i,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       cmd_i,
  input  logic [7:0]       pid_i,
  input  logic [3:0]       seg_id_i,
  input  logic [12:0]      size_i,
  input  logic [11:0]      offset_i,
  input  logic [12:0]      length_i,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status_o,
  output logic [11:0]      address_o
);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_FIND     = 13'b0000000000100,  // look up pid/seg_id, also free slot
    S_HSCAN    = 13'b0000000001000,  // hole scan for create
    S_CWRITE   = 13'b0000000010000,  // access: bounds check on the found segment
    S_MERGE    = 13'b0000000100000,  // delete: merge neighbours
    S_HSLOT    = 13'b0000001000000,  // delete: write merged hole
    S_CPICK    = 13'b0000010000000,  // compact: pick lowest unplaced
    S_CPLACE   = 13'b0000100000000,
    S_CHCLR    = 13'b0001000000000,  // compact: clear hole table
    S_FSCAN    = 13'b0010000000000,  // free: next matching segment
    S_RESP     = 13'b0100000000000,
    S_RDWAIT   = 13'b1000000000000   // memory read latency
  } state_e;

  // tables live in memories, with valid bits in flops
  seg_t  seg_mem  [MaxSegments];
  hole_t hole_mem [MaxHoles];
  logic [MaxSegments-1:0] seg_v_q, seg_v_d;
  logic [MaxSegments-1:0] placed_q, placed_d;
  logic [MaxHoles-1:0]    hole_v_q, hole_v_d;

  state_e state_q, state_d, ret_q, ret_d;
  logic [12:0] mem_size_q, mem_size_d, res_size_q, res_size_d;
  logic [1:0]  fit_q, fit_d;

  logic [2:0]  cmd_q, cmd_d;
  logic [7:0]  pid_q, pid_d;
  logic [3:0]  sid_q, sid_d;
  logic [12:0] size_q, size_d, len_q, len_d;
  logic [11:0] off_q, off_d;

  logic [SegCntW-1:0]  si_q, si_d;      // segment scan index
  logic [HoleCntW-1:0] hi_q, hi_d;      // hole scan index
  logic                found_q, found_d;
  logic [SegIdxW-1:0]  fidx_q, fidx_d;  // found segment
  logic                slot_ok_q, slot_ok_d;
  logic [SegIdxW-1:0]  slot_q, slot_d;
  logic                pick_ok_q, pick_ok_d;
  logic [HoleIdxW-1:0] pick_q, pick_d;
  hole_t               pickh_q, pickh_d;
  logic [13:0]         free_q, free_d;
  logic [12:0]         b_q, b_d, s_q, s_d;   // hole under merge
  logic [13:0]         cur_q, cur_d;
  logic [1:0]          st_q, st_d;
  logic [11:0]         addr_q, addr_d;
  logic                ov_q, ov_d;
  logic [1:0]          ost_q, ost_d;     // output register
  logic [11:0]         oaddr_q, oaddr_d;

  // memory ports
  logic               sw_en;
  logic [SegIdxW-1:0] sw_a;
  seg_t               sw_d;
  logic [SegIdxW-1:0] sr_a;
  seg_t               sr_q;
  logic               hw_en;
  logic [HoleIdxW-1:0] hw_a;
  hole_t              hw_d;
  logic [HoleIdxW-1:0] hr_a;
  hole_t              hr_q;

  always_ff @(posedge clk_i) begin
    if (sw_en) seg_mem[sw_a] <= sw_d;
    sr_q <= seg_mem[sr_a];
  end
  always_ff @(posedge clk_i) begin
    if (hw_en) hole_mem[hw_a] <= hw_d;
    hr_q <= hole_mem[hr_a];
  end

  // effective sizes
  logic [12:0] eff_mem, eff_res;
  always_comb begin
    eff_mem = (mem_size_q > 13'(MemBytes)) ? 13'(MemBytes) : mem_size_q;
    eff_res = (res_size_q > eff_mem) ? eff_mem : res_size_q;
  end

  logic cfg_fire, in_fire;
  assign cfg_ready = (state_q == S_IDLE) && !ov_q;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = !((state_q == S_IDLE) && !cfg_valid);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = ov_q;
  assign status_o  = ost_q;
  assign address_o = oaddr_q;

  // scan index of the previous cycle's read
  logic [SegIdxW-1:0]  sprev;
  logic [HoleIdxW-1:0] hprev;
  assign sprev = SegIdxW'(si_q - SegCntW'(1));
  assign hprev = HoleIdxW'(hi_q - HoleCntW'(1));

  logic [12:0] hend, send;
  logic [13:0] acc_end;
  logic        better;

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    mem_size_d = mem_size_q; res_size_d = res_size_q; fit_d = fit_q;
    cmd_d = cmd_q; pid_d = pid_q; sid_d = sid_q; size_d = size_q;
    len_d = len_q; off_d = off_q;
    seg_v_d = seg_v_q; hole_v_d = hole_v_q; placed_d = placed_q;
    si_d = si_q; hi_d = hi_q; found_d = found_q; fidx_d = fidx_q;
    slot_ok_d = slot_ok_q; slot_d = slot_q; pick_ok_d = pick_ok_q;
    pick_d = pick_q; pickh_d = pickh_q; free_d = free_q;
    b_d = b_q; s_d = s_q; cur_d = cur_q; st_d = st_q; addr_d = addr_q; ov_d = ov_q;
    ost_d = ost_q; oaddr_d = oaddr_q;
    sw_en = 1'b0; sw_a = '0; sw_d = '0;
    hw_en = 1'b0; hw_a = '0; hw_d = '0;
    sr_a = SegIdxW'(si_q); hr_a = HoleIdxW'(hi_q);
    hend = hr_q.base + hr_q.size;
    send = b_q + s_q;
    acc_end = {1'b0, off_q} + {1'b0, len_q};
    better = 1'b0;

    if (ov_q && !out_stall) ov_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        // rebuild: segment 0 reserved, one hole after it when memory remains
        seg_v_d = '0; seg_v_d[0] = 1'b1;
        hole_v_d = '0;
        sw_en = 1'b1; sw_a = '0;
        sw_d = '{pid: '0, seg_id: '0, base: '0, size: eff_res};
        hw_en = 1'b1; hw_a = '0;
        hw_d = '{base: eff_res, size: eff_mem - eff_res};
        hole_v_d[0] = eff_mem > eff_res;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_fire) begin
          unique case (reg_e'(cfg_index_i))
            REG_MEM_SIZE: begin mem_size_d = cfg_data_i; state_d = S_CLEAR; end
            REG_RES_SIZE: begin res_size_d = cfg_data_i; state_d = S_CLEAR; end
            REG_FIT:      fit_d = cfg_data_i[1:0];
            default: ;
          endcase
        end else if (in_fire) begin
          cmd_d = cmd_i; pid_d = pid_i; sid_d = seg_id_i; size_d = size_i;
          off_d = offset_i; len_d = length_i;
          st_d = ST_FAULT; addr_d = '0;
          si_d = SegCntW'(1); found_d = 1'b0; slot_ok_d = 1'b0;
          unique case (cmd_i)
            CMD_CREATE, CMD_DELETE, CMD_ACCESS: begin
              ret_d = S_FIND; state_d = S_RDWAIT;
            end
            CMD_FREE: begin ret_d = S_FSCAN; state_d = S_RDWAIT; end
            CMD_COMPACT: begin
              placed_d = '0; cur_d = {1'b0, eff_res};
              hi_d = '0; state_d = S_CHCLR; st_d = ST_OK;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_RDWAIT: begin
        si_d = si_q + SegCntW'(1);
        hi_d = hi_q + HoleCntW'(1);
        state_d = ret_q;
      end
      S_FIND: begin
        // sr_q holds entry sprev
        if (seg_v_q[sprev] && !found_q && sr_q.pid == pid_q && sr_q.seg_id == sid_q) begin
          found_d = 1'b1; fidx_d = sprev;
        end
        if (!seg_v_q[sprev] && !slot_ok_q) begin
          slot_ok_d = 1'b1; slot_d = sprev;
        end
        si_d = si_q + SegCntW'(1);
        if (si_q == SegCntW'(MaxSegments)) begin
          unique case (cmd_q)
            CMD_CREATE: begin
              if (size_q == '0 || found_d) state_d = S_RESP;
              else if (!slot_ok_d) begin st_d = ST_OOM; state_d = S_RESP; end
              else begin
                hi_d = '0; pick_ok_d = 1'b0; free_d = '0;
                ret_d = S_HSCAN; state_d = S_RDWAIT;
              end
            end
            CMD_ACCESS: begin
              si_d = SegCntW'(fidx_d); ret_d = S_RESP;
              state_d = found_d ? S_RDWAIT : S_RESP;
              if (found_d) ret_d = S_CWRITE;
            end
            default: begin // delete
              if (found_d) begin
                si_d = SegCntW'(fidx_d); hi_d = '0;
                ret_d = S_MERGE; state_d = S_RDWAIT; b_d = '0;
                slot_ok_d = 1'b0;
              end else state_d = S_RESP;
            end
          endcase
        end
      end
      S_HSCAN: begin
        if (hole_v_q[hprev]) begin
          free_d = free_q + {1'b0, hr_q.size};
          if (hr_q.size >= size_q) begin
            unique case (fit_e'(fit_q))
              FIT_BEST:  better = hr_q.size < pickh_q.size ||
                         (hr_q.size == pickh_q.size && hr_q.base < pickh_q.base);
              FIT_WORST: better = hr_q.size > pickh_q.size ||
                         (hr_q.size == pickh_q.size && hr_q.base < pickh_q.base);
              default:   better = hr_q.base < pickh_q.base;
            endcase
            if (!pick_ok_q || better) begin
              pick_ok_d = 1'b1; pick_d = hprev; pickh_d = hr_q;
            end
          end
        end
        hi_d = hi_q + HoleCntW'(1);
        if (hi_q == HoleCntW'(MaxHoles)) begin
          if (!pick_ok_d) begin
            st_d = (free_d >= {1'b0, size_q}) ? ST_COMPACT : ST_OOM;
            state_d = S_RESP;
          end else begin
            seg_v_d[slot_q] = 1'b1;
            sw_en = 1'b1; sw_a = slot_q;
            sw_d = '{pid: pid_d, seg_id: sid_q, base: pickh_d.base, size: size_q};
            hw_en = 1'b1; hw_a = pick_d;
            hw_d = '{base: pickh_d.base + size_q, size: pickh_d.size - size_q};
            if (pickh_d.size == size_q) hole_v_d[pick_d] = 1'b0;
            st_d = ST_OK; addr_d = pickh_d.base[11:0];
            state_d = S_RESP;
          end
        end
      end
      S_CWRITE: begin
        // access check on the found entry
        if (acc_end <= {1'b0, sr_q.size}) begin
          st_d = ST_OK; addr_d = 12'(sr_q.base + 13'(off_q));
        end
        state_d = S_RESP;
      end
      S_MERGE: begin
        // on entry it latches the deleted segment, then walks the holes
        if (!slot_ok_q) begin
          b_d = sr_q.base; s_d = sr_q.size; slot_ok_d = 1'b1;
          seg_v_d[fidx_q] = 1'b0;
          hi_d = '0; hr_a = '0; state_d = S_RDWAIT;
        end else begin
          if (hole_v_q[hprev]) begin
            if (hend == b_q) begin
              b_d = hr_q.base; s_d = s_q + hr_q.size; hole_v_d[hprev] = 1'b0;
            end else if (send == hr_q.base) begin
              s_d = s_q + hr_q.size; hole_v_d[hprev] = 1'b0;
            end
          end
          hi_d = hi_q + HoleCntW'(1);
          if (hi_q == HoleCntW'(MaxHoles)) state_d = S_HSLOT;
        end
      end
      S_HSLOT: begin
        st_d = ST_OK;
        if (&hole_v_q) begin
          placed_d = '0; cur_d = {1'b0, eff_res}; hi_d = '0; state_d = S_CHCLR;
        end else begin
          for (int i = MaxHoles - 1; i >= 0; i--)
            if (!hole_v_q[i]) hw_a = HoleIdxW'(i);
          hw_en = 1'b1; hw_d = '{base: b_q, size: s_q};
          hole_v_d[hw_a] = 1'b1;
          state_d = (cmd_q == CMD_FREE) ? S_RDWAIT : S_RESP;
          ret_d = S_FSCAN; si_d = SegCntW'(fidx_q) + SegCntW'(1);
        end
      end
      S_CHCLR: begin
        hole_v_d = '0; found_d = 1'b0; si_d = SegCntW'(1);
        ret_d = S_CPICK; state_d = S_RDWAIT;
      end
      S_CPICK: begin
        // find unplaced valid segment with the lowest base
        if (seg_v_q[sprev] && !placed_q[sprev] &&
            (!found_q || sr_q.base < pickh_q.base)) begin
          found_d = 1'b1; fidx_d = sprev; pickh_d.base = sr_q.base;
        end
        si_d = si_q + SegCntW'(1);
        if (si_q == SegCntW'(MaxSegments)) begin
          if (found_d) begin
            si_d = SegCntW'(fidx_d); ret_d = S_CPLACE; state_d = S_RDWAIT;
          end else begin
            if (cur_q < {1'b0, eff_mem}) begin
              hw_en = 1'b1; hw_a = '0;
              hw_d = '{base: cur_q[12:0], size: eff_mem - cur_q[12:0]};
              hole_v_d[0] = 1'b1;
            end
            // free process rescans from the start; earlier matches are gone
            state_d = (cmd_q == CMD_FREE) ? S_RDWAIT : S_RESP;
            ret_d = S_FSCAN; si_d = SegCntW'(1);
          end
        end
      end
      S_CPLACE: begin
        placed_d[fidx_q] = 1'b1;
        sw_en = 1'b1; sw_a = fidx_q;
        sw_d = sr_q; sw_d.base = cur_q[12:0];
        cur_d = cur_q + {1'b0, sr_q.size};
        found_d = 1'b0; si_d = SegCntW'(1);
        ret_d = S_CPICK; state_d = S_RDWAIT;
      end
      S_FSCAN: begin
        // delete next segment of the process; fidx_q tracks position
        st_d = ST_OK;
        if (si_q > SegCntW'(MaxSegments)) state_d = S_RESP;
        else if (seg_v_q[sprev] && sr_q.pid == pid_q) begin
          fidx_d = sprev; si_d = SegCntW'(sprev); hi_d = '0;
          b_d = sr_q.base; s_d = sr_q.size; slot_ok_d = 1'b1;
          seg_v_d[sprev] = 1'b0; state_d = S_RDWAIT; ret_d = S_MERGE;
          fidx_d = sprev;
        end else begin
          si_d = si_q + SegCntW'(1);
          if (si_q == SegCntW'(MaxSegments)) state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!ov_q || !out_stall) begin
          ov_d = 1'b1; ost_d = st_q; oaddr_d = addr_q; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; ret_q <= S_IDLE;
      mem_size_q <= 13'd4096; res_size_q <= 13'd128; fit_q <= FIT_BEST;
      seg_v_q <= '0; hole_v_q <= '0; placed_q <= '0; ov_q <= 1'b0;
      found_q <= 1'b0; slot_ok_q <= 1'b0; pick_ok_q <= 1'b0;
      si_q <= '0; hi_q <= '0;
    end else begin
      state_q <= state_d; ret_q <= ret_d;
      mem_size_q <= mem_size_d; res_size_q <= res_size_d; fit_q <= fit_d;
      seg_v_q <= seg_v_d; hole_v_q <= hole_v_d; placed_q <= placed_d; ov_q <= ov_d;
      found_q <= found_d; slot_ok_q <= slot_ok_d; pick_ok_q <= pick_ok_d;
      si_q <= si_d; hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; pid_q <= pid_d; sid_q <= sid_d; size_q <= size_d;
    len_q <= len_d; off_q <= off_d; fidx_q <= fidx_d; slot_q <= slot_d;
    pick_q <= pick_d; pickh_q <= pickh_d; free_q <= free_d; b_q <= b_d; s_q <= s_d;
    cur_q <= cur_d; st_q <= st_d; addr_q <= addr_d;
    ost_q <= ost_d; oaddr_q <= oaddr_d;
  end

endmodule

[sv/sawfp_checker.sv]
// port-level checker for the segment allocator, bound to the top level
// depends on sawfp_pkg
module sawfp_checker
  import sawfp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status_o,
  input logic [11:0] address_o,
  input logic        cfg_ready
);
  // a result is held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(status_o) && $stable(address_o))
    else $error("result changed under stall");
  // a transaction accepted means busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted while busy");
  // only ok results carry an address
  a_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o != ST_OK |-> address_o == '0)
    else $error("address on failed result");
  // no config while a result waits
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !cfg_ready)
    else $error("config open with pending result");
endmodule

bind segment_allocator_with_fit_policies sawfp_checker u_sawfp_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
  .status_o, .address_o, .cfg_ready
);
